// File: design/circular_double_ended_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circular deque unit
// Clocked property checks on clk_i, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// check a property outside reset
`define CDEQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property at every edge, reset included
`define CDEQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/cdeq_pkg.sv
// ----------------------------------------------------------------------------
// cdeq_pkg
// Types and constants of the circular double-ended queue unit.
// ----------------------------------------------------------------------------
package cdeq_pkg;

  localparam int unsigned DepthDefault = 8;
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned ReqWidth     = 3;
  localparam int unsigned StatusWidth  = 2;

  typedef enum logic [ReqWidth-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_LIST       = 3'd4
  } req_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_POP  = 2'd1,
    S_LIST = 2'd2
  } state_e;

endpackage

// File: design/circular_double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit
// Circular deque of 32-bit words held in one synchronous RAM, with push and
// pop at either end and a front-to-back listing of the contents.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata          | tuser         | tlast
//  ---------+-----+----------------+---------------+----------------------
//  s_axis   | in  | item_value     | req_type      | -
//  m_axis   | out | word_out       | status        | last result of request
//
//  Push and refused requests load the result register directly. Pop reads
//  the slot RAM's registered read port, then S_POP loads the result. List
//  reads one RAM word per stored word. One request is in progress at a time.
//  Reset clears the pointers, the empty flag and the output valid flag; the
//  slot RAM keeps its contents and is never read before it is written.
//  A stalled m_axis holds the result register and pauses the listing.
// ----------------------------------------------------------------------------
`include "circular_double_ended_queue_unit_assert.svh"

module circular_double_ended_queue_unit #(
  parameter int unsigned DEPTH = cdeq_pkg::DepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [cdeq_pkg::WordWidth-1:0]     s_axis_tdata_i,  // [31:0] item_value
  input  logic [cdeq_pkg::ReqWidth-1:0]      s_axis_tuser_i,  // [2:0] req_type
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [cdeq_pkg::WordWidth-1:0]     m_axis_tdata_o,  // [31:0] word_out
  output logic [cdeq_pkg::StatusWidth-1:0]   m_axis_tuser_o,  // [1:0] status
  output logic                               m_axis_tlast_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - 1'b1;
  endfunction

  cdeq_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [IdxW-1:0]  list_q, list_d;
  logic             empty_q, empty_d;

  logic                          out_valid_q;
  logic                          out_load;
  cdeq_pkg::status_e             out_status_q, out_status_d;
  logic [cdeq_pkg::WordWidth-1:0] out_word_q, out_word_d;
  logic                          out_last_q, out_last_d;
  logic                          out_free;

  logic [cdeq_pkg::WordWidth-1:0] slot_mem [DEPTH];
  logic                          wr_en, rd_en;
  logic [IdxW-1:0]               wr_addr, rd_addr;
  logic [cdeq_pkg::WordWidth-1:0] rd_data_q;

  logic              in_xfer;
  logic              full;
  cdeq_pkg::req_e    req;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == cdeq_pkg::S_IDLE) && out_free;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = !empty_q && (idx_inc(tail_q) == head_q);
  assign req             = cdeq_pkg::req_e'(s_axis_tuser_i);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    list_d       = list_q;
    empty_d      = empty_q;
    wr_en        = 1'b0;
    wr_addr      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    out_load     = 1'b0;
    out_status_d = cdeq_pkg::STATUS_DONE;
    out_word_d   = '0;
    out_last_d   = 1'b1;

    unique case (state_q)
      cdeq_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (req)
            cdeq_pkg::REQ_PUSH_FRONT, cdeq_pkg::REQ_PUSH_BACK: begin
              out_load = 1'b1;
              if (full) begin
                out_status_d = cdeq_pkg::STATUS_FULL;
              end else if (empty_q) begin
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b0;
                wr_en   = 1'b1;
                wr_addr = '0;
              end else if (req == cdeq_pkg::REQ_PUSH_FRONT) begin
                head_d  = idx_dec(head_q);
                wr_en   = 1'b1;
                wr_addr = idx_dec(head_q);
              end else begin
                tail_d  = idx_inc(tail_q);
                wr_en   = 1'b1;
                wr_addr = idx_inc(tail_q);
              end
            end
            cdeq_pkg::REQ_POP_FRONT, cdeq_pkg::REQ_POP_BACK: begin
              if (empty_q) begin
                out_load     = 1'b1;
                out_status_d = cdeq_pkg::STATUS_EMPTY;
              end else begin
                // read the word now into the read register; S_POP then loads it as the result
                rd_en   = 1'b1;
                rd_addr = (req == cdeq_pkg::REQ_POP_FRONT) ? head_q : tail_q;
                state_d = cdeq_pkg::S_POP;
                if (head_q == tail_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                  empty_d = 1'b1;
                end else if (req == cdeq_pkg::REQ_POP_FRONT) begin
                  head_d = idx_inc(head_q);
                end else begin
                  tail_d = idx_dec(tail_q);
                end
              end
            end
            cdeq_pkg::REQ_LIST: begin
              if (empty_q) begin
                out_load     = 1'b1;
                out_status_d = cdeq_pkg::STATUS_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                list_d  = head_q;
                state_d = cdeq_pkg::S_LIST;
              end
            end
            default: begin
              // unused codes: drop without a result
            end
          endcase
        end
      end
      cdeq_pkg::S_POP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_word_d = rd_data_q;
          state_d    = cdeq_pkg::S_IDLE;
        end
      end
      cdeq_pkg::S_LIST: begin
        // read data stays put while the output stalls
        if (out_free) begin
          out_load   = 1'b1;
          out_word_d = rd_data_q;
          out_last_d = (list_q == tail_q);
          if (list_q == tail_q) begin
            state_d = cdeq_pkg::S_IDLE;
          end else begin
            list_d  = idx_inc(list_q);
            rd_en   = 1'b1;
            rd_addr = idx_inc(list_q);
          end
        end
      end
      default: begin
        state_d = cdeq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdeq_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      list_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      list_q  <= list_d;
      empty_q <= empty_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_word_q   <= out_word_d;
      out_last_q   <= out_last_d;
    end
  end

  // slot RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= slot_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  `CDEQ_ASSERT(a_empty_ptrs_zero, empty_q |-> (head_q == '0 && tail_q == '0), "empty deque with nonzero pointers")
  `CDEQ_ASSERT(a_pop_reads, (in_xfer && !empty_q && (req == cdeq_pkg::REQ_POP_FRONT || req == cdeq_pkg::REQ_POP_BACK)) |=> (state_q == cdeq_pkg::S_POP), "pop did not wait for read data")
  `CDEQ_ASSERT(a_pop_out_free, (state_q == cdeq_pkg::S_POP) |-> !out_valid_q, "pop result would overwrite a pending result")
  `CDEQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o, "result valid after a reset cycle")

endmodule
